// ===== hw/rtl/cmap_format4_glyph_lookup_top_assert.svh =====
// Assertion macros shared by the lookup block.
`ifndef CMAP_FORMAT4_GLYPH_LOOKUP_TOP_ASSERT_SVH
`define CMAP_FORMAT4_GLYPH_LOOKUP_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CFGL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfgl assertion failed");
`define CFGL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfgl assertion failed");
`else
`define CFGL_ASSERT_NOW(lbl, ante, cons)
`define CFGL_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/cfgl_pkg.sv =====
package cfgl_pkg;

  localparam int unsigned CodeW   = 16;
  localparam int unsigned CharW   = 21;
  localparam int unsigned SlotW   = 10;
  localparam int unsigned CountW  = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned IdxW    = 19;

  localparam logic [1:0] REQ_SEG_LOAD   = 2'd0;
  localparam logic [1:0] REQ_GLYPH_LOAD = 2'd1;
  localparam logic [1:0] REQ_LOOKUP     = 2'd2;

  localparam logic [StatusW-1:0] STS_MAPPED = 2'd0;
  localparam logic [StatusW-1:0] STS_RANGE  = 2'd1;
  localparam logic [StatusW-1:0] STS_MISS   = 2'd2;
  localparam logic [StatusW-1:0] STS_BADIDX = 2'd3;

  localparam logic REG_SEG_COUNT = 1'b0;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [SlotW-1:0] slot;
    logic [CodeW-1:0] end_code;
    logic [CodeW-1:0] start_code;
    logic [CodeW-1:0] id_delta;
    logic [CodeW-1:0] range_offset;
    logic [CodeW-1:0] glyph_word;
    logic [CharW-1:0] char_code;
  } req_t;

  typedef struct packed {
    logic [CodeW-1:0]   glyph_id;
    logic [StatusW-1:0] status;
  } res_t;

  typedef enum logic [2:0] {
    RES_NONE,
    RES_RANGE,
    RES_MISS,
    RES_EVAL,
    RES_GLYPH
  } res_op_e;

  typedef struct packed {
    logic    seg_we;
    logic    glyph_we;
    logic    lookup_start;
    logic    scan;
    logic    hold;
    logic    glyph_rd;
    res_op_e res_op;
  } cmd_t;

  typedef struct packed {
    logic code_high;
    logic hit;
    logic exhausted;
    logic need_glyph;
  } sts_t;

endpackage

// ===== hw/rtl/cfgl_ctrl.sv =====
`include "cmap_format4_glyph_lookup_top_assert.svh"

module cfgl_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [1:0]      req_type_i,
  input  cfgl_pkg::sts_t  sts_i,
  output cfgl_pkg::cmd_t  cmd_o,
  output logic            busy,
  output logic            res_valid_o
);
  import cfgl_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCAN  = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_GWAIT = 3'd3;

  logic [2:0] state_q, state_d;
  logic       res_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '{default: '0, res_op: RES_NONE};
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (req_type_i)
            REQ_SEG_LOAD:   cmd_o.seg_we = 1'b1;
            REQ_GLYPH_LOAD: cmd_o.glyph_we = 1'b1;
            REQ_LOOKUP: begin
              if (sts_i.code_high) begin
                cmd_o.res_op = RES_RANGE;
              end else begin
                cmd_o.lookup_start = 1'b1;
                state_d = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.hold = 1'b1;
          state_d = ST_EVAL;
        end else if (sts_i.exhausted) begin
          cmd_o.res_op = RES_MISS;
          state_d = ST_IDLE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_EVAL: begin
        if (sts_i.need_glyph) begin
          cmd_o.glyph_rd = 1'b1;
          state_d = ST_GWAIT;
        end else begin
          cmd_o.res_op = RES_EVAL;
          state_d = ST_IDLE;
        end
      end
      ST_GWAIT: begin
        cmd_o.res_op = RES_GLYPH;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (cmd_o.res_op != RES_NONE);
    end
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = res_valid_q;

  `CFGL_ASSERT_NOW(a_word_in_idle, res_valid_q, state_q == ST_IDLE)
  `CFGL_ASSERT_NEXT(a_hit_to_eval, (state_q == ST_SCAN) && sts_i.hit, state_q == ST_EVAL)
  `CFGL_ASSERT_NOW(a_eval_after_scan, state_q == ST_EVAL, $past(state_q) == ST_SCAN)

endmodule

// ===== hw/rtl/cfgl_dp.sv =====
`include "cmap_format4_glyph_lookup_top_assert.svh"

module cfgl_dp #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned GLYPH_WORDS  = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cfgl_pkg::req_t                req_i,
  input  logic [cfgl_pkg::CountW-1:0]   seg_count_i,
  input  cfgl_pkg::cmd_t                cmd_i,
  output cfgl_pkg::sts_t                sts_o,
  output cfgl_pkg::res_t                res_o
);
  import cfgl_pkg::*;

  localparam int unsigned SegAw   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned GlyphAw = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
  localparam int unsigned NumW    = $clog2(MAX_SEGMENTS + 1);

  logic [4*CodeW-1:0] seg_mem [MAX_SEGMENTS];
  logic [CodeW-1:0]   glyph_mem [GLYPH_WORDS];

  logic [NumW-1:0]    n_q, i_q, ridx_q, hidx_q;
  logic               rvalid_q;
  logic [CodeW-1:0]   code_q;
  logic [4*CodeW-1:0] seg_rd_q;
  logic [CodeW-1:0]   hstart_q, hdelta_q, hro_q;
  logic [CodeW-1:0]   glyph_rd_q;
  res_t               res_q;

  logic [CodeW-1:0]   rd_end;
  logic [NumW-1:0]    n_sat;
  logic               seg_slot_ok, glyph_slot_ok;
  logic               below_start, idx_ok;
  logic [IdxW-1:0]    idx;

  assign seg_slot_ok   = ({1'b0, req_i.slot} < (SlotW + 1)'(MAX_SEGMENTS));
  assign glyph_slot_ok = (CodeW'(req_i.slot) < CodeW'(GLYPH_WORDS));
  assign n_sat = ((SlotW + 1)'(seg_count_i) > (SlotW + 1)'(MAX_SEGMENTS)) ?
                 NumW'(MAX_SEGMENTS) : NumW'(seg_count_i);

  assign rd_end      = seg_rd_q[4*CodeW-1:3*CodeW];
  assign below_start = (hstart_q > code_q);
  assign idx = IdxW'(hro_q[CodeW-1:1]) + IdxW'(code_q) - IdxW'(hstart_q)
             - IdxW'(n_q - hidx_q);
  assign idx_ok = !idx[IdxW-1] && (idx[IdxW-2:0] < (IdxW - 1)'(GLYPH_WORDS));

  assign sts_o.code_high  = (req_i.char_code[CharW-1:CodeW] != '0);
  assign sts_o.hit        = rvalid_q && (rd_end >= code_q);
  assign sts_o.exhausted  = !rvalid_q && (i_q == n_q);
  assign sts_o.need_glyph = !below_start && (hro_q != '0) && idx_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.seg_we && seg_slot_ok) begin
      seg_mem[SegAw'(req_i.slot)] <= {req_i.end_code, req_i.start_code,
                                      req_i.id_delta, req_i.range_offset};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && (i_q < n_q)) begin
      seg_rd_q <= seg_mem[i_q[SegAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.glyph_we && glyph_slot_ok) begin
      glyph_mem[GlyphAw'(req_i.slot)] <= req_i.glyph_word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.glyph_rd) begin
      glyph_rd_q <= glyph_mem[GlyphAw'(idx)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q      <= '0;
      i_q      <= '0;
      ridx_q   <= '0;
      rvalid_q <= 1'b0;
    end else if (cmd_i.lookup_start) begin
      n_q      <= n_sat;
      i_q      <= '0;
      rvalid_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (i_q < n_q) begin
        i_q      <= i_q + 1'b1;
        ridx_q   <= i_q;
        rvalid_q <= 1'b1;
      end else begin
        rvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup_start) begin
      code_q <= req_i.char_code[CodeW-1:0];
    end
    if (cmd_i.hold) begin
      hstart_q <= seg_rd_q[3*CodeW-1:2*CodeW];
      hdelta_q <= seg_rd_q[2*CodeW-1:CodeW];
      hro_q    <= seg_rd_q[CodeW-1:0];
      hidx_q   <= ridx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.res_op)
      RES_RANGE: res_q <= '{glyph_id: '0, status: STS_RANGE};
      RES_MISS:  res_q <= '{glyph_id: '0, status: STS_MISS};
      RES_EVAL: begin
        if (below_start) begin
          res_q <= '{glyph_id: '0, status: STS_MISS};
        end else if (hro_q == '0) begin
          res_q <= '{glyph_id: hdelta_q + code_q, status: STS_MAPPED};
        end else begin
          res_q <= '{glyph_id: '0, status: STS_BADIDX};
        end
      end
      RES_GLYPH: begin
        res_q <= '{glyph_id: (glyph_rd_q != '0) ? glyph_rd_q + hdelta_q : '0,
                   status: STS_MAPPED};
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  `CFGL_ASSERT_NOW(a_scan_bound, 1'b1, i_q <= n_q)
  `CFGL_ASSERT_NOW(a_read_behind, rvalid_q, ridx_q < i_q)
  `CFGL_ASSERT_NEXT(a_start_clears, cmd_i.lookup_start, !rvalid_q && (i_q == '0))

endmodule

// ===== hw/rtl/cmap_format4_glyph_lookup_top.sv =====
// Character-to-glyph lookup over a cmap format 4 segment table. Segment and
// glyph-array loads give no word. A lookup of a code above 0xFFFF answers
// in the cycle after it is taken; any other lookup keeps busy high while
// the scan reads one segment end code per cycle from the segment memory,
// over at most segment_count segments capped at MAX_SEGMENTS, then forms
// the glyph index and, where needed, reads the glyph memory. Each result
// word is shown for one cycle with res_valid_o and cannot be held off, so
// it must be taken when shown.
module cmap_format4_glyph_lookup_top #(
  parameter int unsigned MAX_SEGMENTS = 64,
  parameter int unsigned GLYPH_WORDS  = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  cfgl_pkg::req_t  req_i,
  output logic            res_valid_o,
  output cfgl_pkg::res_t  res_o,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);
  import cfgl_pkg::*;

  logic [CountW-1:0] seg_count_q;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_count_q <= CountW'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEG_COUNT)) begin
      seg_count_q <= pwdata[CountW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_SEG_COUNT) ? 32'(seg_count_q) : '0;

  cfgl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_type_i  (req_i.req_type),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy        (busy),
    .res_valid_o (res_valid_o)
  );

  cfgl_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .GLYPH_WORDS  (GLYPH_WORDS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .seg_count_i (seg_count_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_o       (res_o)
  );

endmodule

// ===== bench/cmap_format4_glyph_lookup_top_tb.sv =====
module cmap_format4_glyph_lookup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfgl_pkg::*;

  localparam int MAX_SEGS = 64;
  localparam int GLYPHS = 1024;
  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam int DRAIN_CYCLES = MAX_SEGS + 8;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_WORDS = 150;

  class glyph_lookup_checker;
    logic [CodeW-1:0] seg_end[MAX_SEGS];
    logic [CodeW-1:0] seg_start[MAX_SEGS];
    logic [CodeW-1:0] seg_delta[MAX_SEGS];
    logic [CodeW-1:0] seg_ro[MAX_SEGS];
    bit seg_wr[MAX_SEGS];
    logic [CodeW-1:0] glyph_mem[GLYPHS];
    bit glyph_wr[GLYPHS];
    int unsigned seg_count = 1;
    res_t pending_glyphs[$];
    int errors;

    // Works out the answer to a lookup and reports the first segment or glyph
    // word that it would read before that entry has been loaded.
    function void resolve(logic [CharW-1:0] code, output res_t r, output int seg_hole,
                          output int glyph_hole);
      int n, i, idx, half_ro, off, st;
      logic [CodeW-1:0] g;
      r = '0;
      seg_hole = -1;
      glyph_hole = -1;
      if (code > 21'h00FFFF) begin
        r.status = STS_RANGE;
        return;
      end
      n = (seg_count > MAX_SEGS) ? MAX_SEGS : seg_count;
      for (i = 0; i < n; i++) begin
        if (!seg_wr[i] && seg_hole < 0) seg_hole = i;
        if (seg_end[i] >= code[15:0]) break;
      end
      r.status = STS_MISS;
      if (i >= n || seg_start[i] > code[15:0]) return;
      r.status = STS_MAPPED;
      if (seg_ro[i] == 0) begin
        r.glyph_id = seg_delta[i] + code[15:0];
        return;
      end
      half_ro = seg_ro[i] >> 1;
      off = code[15:0];
      st = seg_start[i];
      idx = half_ro + off - st - (n - i);
      if (idx < 0 || idx >= GLYPHS) begin
        r.status = STS_BADIDX;
        return;
      end
      if (!glyph_wr[idx]) glyph_hole = idx;
      g = glyph_mem[idx];
      if (g != 0) g = g + seg_delta[i];
      r.glyph_id = g;
    endfunction

    function void note_req(req_t q);
      res_t r;
      int sh, gh;
      case (q.req_type)
        REQ_SEG_LOAD: begin
          if (q.slot < MAX_SEGS) begin
            seg_end[q.slot] = q.end_code;
            seg_start[q.slot] = q.start_code;
            seg_delta[q.slot] = q.id_delta;
            seg_ro[q.slot] = q.range_offset;
            seg_wr[q.slot] = 1'b1;
          end
        end
        REQ_GLYPH_LOAD: begin
          if (q.slot < GLYPHS) begin
            glyph_mem[q.slot] = q.glyph_word;
            glyph_wr[q.slot] = 1'b1;
          end
        end
        REQ_LOOKUP: begin
          resolve(q.char_code, r, sh, gh);
          pending_glyphs.push_back(r);
        end
        default: ;
      endcase
    endfunction

    function void check_res(res_t a);
      res_t e;
      if (pending_glyphs.size() == 0) begin
        errors++;
        $display("%0t: expected no word, actual glyph_id %h status %0d",
                 $time, a.glyph_id, a.status);
        return;
      end
      e = pending_glyphs.pop_front();
      if (a.glyph_id !== e.glyph_id) begin
        errors++;
        $display("%0t: glyph_id expected %h actual %h", $time, e.glyph_id, a.glyph_id);
      end
      if (a.status !== e.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, e.status, a.status);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  glyph_lookup_checker sb;
  int stall_cycles = 0;
  int idle_pct = 28;
  int words_sent = 0;
  int episode_no = 0;

  cmap_format4_glyph_lookup_top #(
    .MAX_SEGMENTS(MAX_SEGS),
    .GLYPH_WORDS(GLYPHS)
  ) uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .req_i(req_i),
    .res_valid_o(res_valid_o),
    .res_o(res_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) sb.note_req(req_i);
    if (rst_ni && res_valid_o) sb.check_res(res_o);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || res_valid_o || (psel && penable && pready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic req_t rand_req();
    req_t r;
    r.req_type = 2'($urandom_range(3));
    r.slot = 10'($urandom);
    r.end_code = 16'($urandom);
    r.start_code = 16'($urandom);
    r.id_delta = 16'($urandom);
    r.range_offset = 16'($urandom);
    r.glyph_word = 16'($urandom);
    r.char_code = 21'($urandom);
    return r;
  endfunction

  function automatic logic [CodeW-1:0] glyph_fill();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_req(req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    if (!(r.req_type == REQ_NOP || (r.req_type == REQ_SEG_LOAD && r.slot >= MAX_SEGS)))
      words_sent++;
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      req_i <= rand_req();
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  endtask

  task automatic send_seg(int slot, int end_c, int start_c, int delta, int ro);
    req_t r;
    r = rand_req();
    r.req_type = REQ_SEG_LOAD;
    r.slot = 10'(slot);
    r.end_code = 16'(end_c);
    r.start_code = 16'(start_c);
    r.id_delta = 16'(delta);
    r.range_offset = 16'(ro);
    send_req(r);
  endtask

  task automatic send_glyph(int slot, logic [CodeW-1:0] w);
    req_t r;
    r = rand_req();
    r.req_type = REQ_GLYPH_LOAD;
    r.slot = 10'(slot);
    r.glyph_word = w;
    send_req(r);
  endtask

  // Unwritten table entries hold undefined data, so whatever the lookup will
  // read is loaded first.
  task automatic send_lookup(logic [CharW-1:0] code);
    req_t r;
    res_t guess;
    int seg_hole, glyph_hole;
    sb.resolve(code, guess, seg_hole, glyph_hole);
    while (seg_hole >= 0 || glyph_hole >= 0) begin
      if (seg_hole >= 0)
        send_seg(seg_hole, $urandom_range(65535), $urandom_range(65535),
                 $urandom_range(65535), $urandom_range(65535));
      else
        send_glyph(glyph_hole, glyph_fill());
      sb.resolve(code, guess, seg_hole, glyph_hole);
    end
    r = rand_req();
    r.req_type = REQ_LOOKUP;
    r.char_code = code;
    send_req(r);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (sb.pending_glyphs.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [CountW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 3'(4 * REG_SEG_COUNT);
    pwdata <= {25'($urandom), val};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.seg_count = val;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Ascending end codes, as a well-formed table has them; start codes and
  // range offsets are varied so that misses and bad indices also occur.
  task automatic build_table(int m, int n_eff);
    int i, prev, avail, e, s, base, ro;
    prev = -1;
    for (i = 0; i < m; i++) begin
      avail = 65535 - (m - 1 - i) - (prev + 1);
      e = prev + 1 + $urandom_range(0, 2 * avail / (m - i + 1));
      if (i == m - 1 && $urandom_range(3) != 0) e = 65535;
      case ($urandom_range(9))
        0: s = $urandom_range(e, 65535);
        1, 2, 3, 4: s = $urandom_range(prev + 1, e);
        default: s = (e - 63 > prev + 1) ? e - $urandom_range(0, 63) : prev + 1;
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: ro = 0;
        4: ro = $urandom_range(65535);
        default: begin
          base = $urandom_range(0, GLYPHS + 19) - 20;
          ro = 2 * (base + n_eff - i) + $urandom_range(1);
          if (ro < 1) ro = 1;
        end
      endcase
      send_seg(i, e, s, $urandom_range(65535), ro);
      prev = e;
    end
  endtask

  task automatic run_directed();
    send_seg(0, 'h00FF, 'h0020, 'hFFF0, 0);
    send_lookup(21'h000041);
    send_lookup(21'h1FFFFF);
    send_lookup(21'h010000);
    send_lookup(21'h00001F);
    send_lookup(21'h00FFFF);
    send_seg(64, 'h1234, 'h0000, 'h0001, 'h0000);
    send_seg(1023, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF);
    send_req('{req_type: REQ_NOP, slot: '1, end_code: '1, start_code: '1,
               id_delta: '1, range_offset: '1, glyph_word: '1, char_code: '1});
    send_seg(1, 'hFFFF, 'hFFFF, 'h0001, 0);
    settle();
    cfg_write(7'd0);
    send_lookup(21'h000030);
    settle();
    cfg_write(7'd2);
    send_lookup(21'h00FFFF);
    send_seg(0, 'h00FF, 'h0020, 'h0005, 24);
    send_glyph(10, 16'h0000);
    send_glyph(11, 16'hFFFF);
    send_lookup(21'h000020);
    send_lookup(21'h000021);
    send_seg(0, 'h00FF, 'h0020, 'h0005, 2);
    send_lookup(21'h000020);
    send_seg(0, 'h00FF, 'h0020, 'h0005, 'hFFFE);
    send_lookup(21'h000020);
    send_seg(0, 'h00FF, 'h0020, 'h0005, 2050);
    send_glyph(1023, 16'h1234);
    send_lookup(21'h000020);
    send_lookup(21'h000000);
    settle();
    cfg_write(7'd127);
    send_seg(0, 'hFFFF, 'h0000, 'h0100, 138);
    send_glyph(5, 16'h0042);
    send_lookup(21'h000000);
  endtask

  task automatic run_episode();
    logic [CountW-1:0] cnt;
    int m, n_eff, i, k, lo, e, s;
    int unsigned code;
    req_t r;
    settle();
    episode_no++;
    case (episode_no)
      1: cnt = 7'd64;
      2: cnt = 7'd127;
      3: cnt = 7'd0;
      4: cnt = 7'd1;
      default: begin
        k = $urandom_range(99);
        if (k < 75) cnt = 7'($urandom_range(1, 8));
        else if (k < 88) cnt = 7'($urandom_range(9, 63));
        else if (k < 94) cnt = 7'($urandom_range(65, 126));
        else cnt = 7'($urandom_range(0, 127));
      end
    endcase
    cfg_write(cnt);
    n_eff = (cnt > MAX_SEGS) ? MAX_SEGS : cnt;
    m = (cnt == 0) ? 3 : n_eff;
    build_table(m, n_eff);
    repeat ($urandom_range(15, 40)) begin
      k = $urandom_range(99);
      if (k < 70) begin
        i = $urandom_range(m - 1);
        lo = (i == 0) ? 0 : sb.seg_end[i - 1] + 1;
        e = sb.seg_end[i];
        s = sb.seg_start[i];
        if (lo > e) lo = e;
        if (s > e || s < lo) s = lo;
        k = $urandom_range(9);
        if (k < 6) code = s + $urandom_range(0, (e - s > 31) ? 31 : e - s);
        else if (k < 8) code = $urandom_range(lo, e);
        else if (k < 9) code = e;
        else code = lo;
        send_lookup(21'(code));
      end else if (k < 80) begin
        send_lookup(21'($urandom >> $urandom_range(11)));
      end else if (k < 88) begin
        send_glyph($urandom_range(GLYPHS - 1), glyph_fill());
      end else begin
        r = rand_req();
        if (r.req_type == REQ_LOOKUP) send_lookup(r.char_code);
        else send_req(r);
      end
    end
  endtask

  initial begin : main
    int ph, goal;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    req_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 28 : (ph == 1) ? 49 : 0;
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) run_episode();
    end
    settle();
    if (sb.errors == 0 && sb.pending_glyphs.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (sb.pending_glyphs.size() != 0)
        $display("%0t: %0d expected words never arrived", $time, sb.pending_glyphs.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
